@@ rtl/kpi_pkg.sv @@
`timescale 1ns / 1ps
package kpi_pkg;

  localparam int ANGLES = 5;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_PUSH   = 3'd1;
  localparam logic [2:0] OP_REPEAT = 3'd2;
  localparam logic [2:0] OP_STOP   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  typedef logic [ANGLES-1:0][15:0] pose_t;

  typedef struct packed {
    pose_t from_p;
    pose_t to_p;
    pose_t cur_p;
  } pose_word_t;

  typedef struct packed {
    pose_t       ang;
    logic [15:0] steps;
  } queue_word_t;

  typedef struct packed {
    logic [15:0] from_a;
    logic [15:0] to_a;
    logic [15:0] now;
    logic [15:0] total;
  } lerp_req_t;

endpackage

@@ rtl/keyframe_pose_interpolator.sv @@
`timescale 1ns / 1ps
// Keyframe pose interpolator for up to JOINTS joints of five Q10.6 angles.
// Input channel (in_valid/in_ready) takes one word per operation: tick,
// push keyframe, set repeat, stop or clear. Output channel (out_valid/
// out_ready) returns exactly one word per operation: the addressed joint's
// current pose, a pose_updated flag and a queue-full status.
// cfg_we/cfg_index/cfg_data write the rest pose; the user is to write it
// only while the block idles, which the block itself does not enforce.
// One operation is in flight at a time. An interpolating tick passes each
// angle in turn through the shared divider (start, multiply, restoring
// divide, capture), plus read, end check, write-back and result read, with
// a queue read and load added when it loads the next keyframe. Stop and
// clear sweep the pose memory joint by joint. in_ready rises again as the
// result word is loaded.
// Pose state lives in a one-port-read synchronous memory, queued keyframes
// in a second memory addressed by joint and slot.
// Reset returns every joint to a zero pose with counter and total of one
// and empty queues. When the receiver stalls the result word is held and
// the block takes the next input word, finishing it only once the held
// word is taken.
module keyframe_pose_interpolator import kpi_pkg::*; #(
  parameter int JOINTS      = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic [2:0]         joint_index,
  input  logic signed [15:0] key_angle_0,
  input  logic signed [15:0] key_angle_1,
  input  logic signed [15:0] key_angle_2,
  input  logic signed [15:0] key_angle_3,
  input  logic signed [15:0] key_angle_4,
  input  logic [15:0]        step_count,
  input  logic               repeat_on,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pose_angle_0,
  output logic signed [15:0] pose_angle_1,
  output logic signed [15:0] pose_angle_2,
  output logic signed [15:0] pose_angle_3,
  output logic signed [15:0] pose_angle_4,
  output logic               pose_updated,
  output logic               status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int JW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = FW + 1;
  localparam int QAW = (JOINTS * QUEUE_DEPTH > 1) ? $clog2(JOINTS * QUEUE_DEPTH) : 1;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_RD        = 4'd1;
  localparam logic [3:0] S_LD        = 4'd2;
  localparam logic [3:0] S_LERP_GO   = 4'd3;
  localparam logic [3:0] S_LERP_WAIT = 4'd4;
  localparam logic [3:0] S_ENDCHK    = 4'd5;
  localparam logic [3:0] S_QRD       = 4'd6;
  localparam logic [3:0] S_QLD       = 4'd7;
  localparam logic [3:0] S_WB        = 4'd8;
  localparam logic [3:0] S_PUSH      = 4'd9;
  localparam logic [3:0] S_SWP_RD    = 4'd10;
  localparam logic [3:0] S_SWP_WR    = 4'd11;
  localparam logic [3:0] S_OUT_RD    = 4'd12;
  localparam logic [3:0] S_OUT_LD    = 4'd13;

  logic [3:0] state;

  // accepted word
  logic [2:0]  op_r;
  logic [2:0]  joint_r;
  pose_t       key_r;
  logic [15:0] steps_r;
  logic        upd_r;
  logic        drop_r;

  pose_t rest_pose;
  logic  repeat_mode;

  // per-joint control
  logic [16:0]   step_now   [JOINTS];
  logic [15:0]   step_total [JOINTS];
  logic [QW-1:0] q_head     [JOINTS];
  logic [FW-1:0] q_fill     [JOINTS];
  logic [JOINTS-1:0] pose_vld;

  // working copy of one joint
  pose_t       w_from;
  pose_t       w_to;
  pose_t       w_cur;
  logic [16:0] w_now;
  logic [15:0] w_total;
  logic [2:0]  ang;
  logic [JW-1:0] swp_idx;

  // pose memory
  pose_word_t pose_mem [JOINTS];
  pose_word_t pose_rd;
  pose_word_t pose_rd_m;
  logic       rd_vld;
  logic          pose_we;
  logic [JW-1:0] pose_waddr;
  logic [JW-1:0] pose_raddr;
  pose_word_t    pose_wdata;

  // queue memory
  queue_word_t q_mem [JOINTS * QUEUE_DEPTH];
  queue_word_t q_rd;
  logic        q_we;
  logic [QAW-1:0] q_waddr;
  logic [QAW-1:0] q_raddr;
  queue_word_t    q_wdata;

  // output register
  pose_t out_pose;
  logic  out_upd;
  logic  out_drop;

  logic [JW-1:0] jsel;
  logic          joint_ok;
  logic [QW-1:0] cur_head;
  logic [FW-1:0] cur_fill;
  logic [SW-1:0] tsum;
  logic [QW-1:0] tail;
  logic [QW-1:0] head_inc;
  logic          q_full;
  logic          in_acc;

  lerp_req_t   lreq;
  logic        lstart;
  logic        ldone;
  logic [15:0] lresult;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign jsel     = JW'(joint_r);
  assign joint_ok = {29'd0, joint_r} < 32'(JOINTS);
  assign cur_head = q_head[jsel];
  assign cur_fill = q_fill[jsel];
  assign tsum     = SW'(cur_head) + SW'(cur_fill);
  assign tail     = (tsum >= SW'(QUEUE_DEPTH)) ? QW'(tsum - SW'(QUEUE_DEPTH)) : QW'(tsum);
  assign head_inc = (cur_head == QW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
  assign q_full   = cur_fill >= FW'(QUEUE_DEPTH);
  assign pose_rd_m = rd_vld ? pose_rd : '0;

  assign q_raddr = QAW'(int'(jsel) * QUEUE_DEPTH + int'(cur_head));
  assign q_waddr = QAW'(int'(jsel) * QUEUE_DEPTH + int'(tail));

  assign pose_raddr = (state == S_SWP_RD || state == S_SWP_WR) ? swp_idx : jsel;

  always_comb begin
    pose_we    = 1'b0;
    pose_waddr = jsel;
    pose_wdata = '{from_p: w_from, to_p: w_to, cur_p: w_cur};
    q_we       = 1'b0;
    q_wdata    = '{ang: key_r, steps: steps_r};
    case (state)
      S_WB: begin
        pose_we = 1'b1;
      end
      S_SWP_WR: begin
        pose_we    = 1'b1;
        pose_waddr = swp_idx;
        if (op_r == OP_CLEAR) begin
          pose_wdata = '{from_p: rest_pose, to_p: rest_pose, cur_p: pose_rd_m.cur_p};
        end else begin
          pose_wdata = '{from_p: pose_rd_m.to_p, to_p: pose_rd_m.to_p,
                         cur_p: pose_rd_m.cur_p};
        end
      end
      S_PUSH: begin
        q_we = joint_ok && !q_full;
      end
      S_QLD: begin
        q_we    = repeat_mode;
        q_wdata = q_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pose_we) begin
      pose_mem[pose_waddr] <= pose_wdata;
    end
    pose_rd <= pose_mem[pose_raddr];
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rd <= q_mem[q_raddr];
  end

  assign lreq   = '{from_a: w_from[ang], to_a: w_to[ang], now: w_now[15:0], total: w_total};
  assign lstart = (state == S_LERP_GO);

  kpi_lerp u_lerp (
    .clk    (clk),
    .rst    (rst),
    .start  (lstart),
    .req    (lreq),
    .done   (ldone),
    .result (lresult)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rest_pose   <= '0;
      repeat_mode <= 1'b0;
      pose_vld    <= '0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
      swp_idx     <= '0;
      ang         <= '0;
      for (int j = 0; j < JOINTS; j++) begin
        step_now[j]   <= 17'd1;
        step_total[j] <= 16'd1;
        q_head[j]     <= '0;
        q_fill[j]     <= '0;
      end
    end else begin
      rd_vld <= pose_vld[pose_raddr];
      if (cfg_we && cfg_index < 3'(ANGLES)) begin
        rest_pose[cfg_index] <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op_r    <= operation;
            joint_r <= joint_index;
            key_r   <= {key_angle_4, key_angle_3, key_angle_2, key_angle_1, key_angle_0};
            steps_r <= step_count;
            upd_r   <= 1'b0;
            drop_r  <= 1'b0;
            swp_idx <= '0;
            case (operation)
              OP_TICK:   state <= S_RD;
              OP_PUSH:   state <= S_PUSH;
              OP_REPEAT: begin
                repeat_mode <= repeat_on;
                state       <= S_OUT_RD;
              end
              OP_STOP, OP_CLEAR: begin
                repeat_mode <= 1'b0;
                for (int j = 0; j < JOINTS; j++) begin
                  q_head[j] <= '0;
                  q_fill[j] <= '0;
                  if (operation == OP_CLEAR) begin
                    step_now[j]   <= 17'd1;
                    step_total[j] <= 16'd1;
                  end
                end
                state <= S_SWP_RD;
              end
              default: state <= S_OUT_RD;
            endcase
          end
        end
        S_RD: begin
          state <= joint_ok ? S_LD : S_OUT_RD;
        end
        S_LD: begin
          w_from  <= pose_rd_m.from_p;
          w_to    <= pose_rd_m.to_p;
          w_cur   <= pose_rd_m.cur_p;
          w_now   <= step_now[jsel];
          w_total <= step_total[jsel];
          ang     <= '0;
          if (step_now[jsel] <= {1'b0, step_total[jsel]}) begin
            upd_r <= 1'b1;
            state <= S_LERP_GO;
          end else begin
            state <= S_ENDCHK;
          end
        end
        S_LERP_GO: begin
          state <= S_LERP_WAIT;
        end
        S_LERP_WAIT: begin
          if (ldone) begin
            w_cur[ang] <= lresult;
            if (ang == 3'(ANGLES - 1)) begin
              w_now <= w_now + 17'd1;
              state <= S_ENDCHK;
            end else begin
              ang   <= ang + 3'd1;
              state <= S_LERP_GO;
            end
          end
        end
        S_ENDCHK: begin
          if (w_now >= {1'b0, w_total}) begin
            w_from <= w_to;
            state  <= (cur_fill != '0) ? S_QRD : S_WB;
          end else begin
            state <= S_WB;
          end
        end
        S_QRD: begin
          state <= S_QLD;
        end
        S_QLD: begin
          // load next keyframe; repeat mode re-queues it at the tail
          w_to    <= q_rd.ang;
          w_total <= q_rd.steps;
          w_now   <= '0;
          if (!repeat_mode) begin
            q_fill[jsel] <= cur_fill - 1'b1;
          end
          q_head[jsel] <= head_inc;
          state        <= S_WB;
        end
        S_WB: begin
          pose_vld[jsel]   <= 1'b1;
          step_now[jsel]   <= w_now;
          step_total[jsel] <= w_total;
          state            <= S_OUT_RD;
        end
        S_PUSH: begin
          if (joint_ok) begin
            if (q_full) begin
              drop_r <= 1'b1;
            end else begin
              q_fill[jsel] <= cur_fill + 1'b1;
            end
          end
          state <= S_OUT_RD;
        end
        S_SWP_RD: begin
          state <= S_SWP_WR;
        end
        S_SWP_WR: begin
          pose_vld[swp_idx] <= 1'b1;
          if (swp_idx == JW'(JOINTS - 1)) begin
            state <= S_OUT_RD;
          end else begin
            swp_idx <= swp_idx + 1'b1;
            state   <= S_SWP_RD;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LD;
        end
        S_OUT_LD: begin
          // hold until the previous result word is taken
          if (!out_valid || out_ready) begin
            out_pose  <= joint_ok ? pose_rd_m.cur_p : '0;
            out_upd   <= upd_r;
            out_drop  <= drop_r;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pose_angle_0 = out_pose[0];
  assign pose_angle_1 = out_pose[1];
  assign pose_angle_2 = out_pose[2];
  assign pose_angle_3 = out_pose[3];
  assign pose_angle_4 = out_pose[4];
  assign pose_updated = out_upd;
  assign status       = out_drop;

endmodule

@@ rtl/kpi_lerp.sv @@
`timescale 1ns / 1ps
module kpi_lerp import kpi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  lerp_req_t   req,
  output logic        done,
  output logic [15:0] result
);

  localparam logic [4:0] LAST_STEP = 5'd16;

  logic        busy;
  logic        in_div;
  logic [4:0]  cnt;
  logic        neg;
  logic [16:0] mag;
  logic [15:0] mult;
  logic [15:0] dvsr;
  logic [15:0] base;
  logic [15:0] rem;
  logic [16:0] dvd;
  logic [16:0] quo;

  logic signed [16:0] diff;
  logic [32:0]        prod;
  logic [16:0]        rem_sh;
  logic               ge;
  logic [16:0]        rem_sub;
  logic [15:0]        term;

  assign diff    = $signed({req.to_a[15], req.to_a}) - $signed({req.from_a[15], req.from_a});
  assign prod    = 33'(mag) * 33'(mult);
  assign rem_sh  = {rem, dvd[16]};
  assign ge      = rem_sh >= {1'b0, dvsr};
  assign rem_sub = rem_sh - {1'b0, dvsr};
  assign term    = neg ? (~quo[15:0] + 16'd1) : quo[15:0];
  assign result  = (dvsr == 16'd0) ? base : base + term;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      in_div <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy   <= 1'b1;
        in_div <= 1'b0;
        neg    <= diff[16];
        mag    <= diff[16] ? 17'(-diff) : 17'(diff);
        mult   <= req.now;
        dvsr   <= req.total;
        base   <= req.from_a;
      end else if (busy) begin
        if (!in_div) begin
          // quotient fits 17 bits since now <= total
          rem    <= prod[32:17];
          dvd    <= prod[16:0];
          quo    <= '0;
          cnt    <= '0;
          in_div <= 1'b1;
        end else begin
          rem <= ge ? rem_sub[15:0] : rem_sh[15:0];
          dvd <= {dvd[15:0], 1'b0};
          quo <= {quo[15:0], ge};
          cnt <= cnt + 5'd1;
          if (cnt == LAST_STEP) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

@@ rtl/kpi_checker.sv @@
`timescale 1ns / 1ps
module kpi_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] pose_angle_0,
  input logic        pose_updated,
  input logic        status
);

  // a stalled result word stays valid and its pose_angle_0 holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pose_angle_0))
    else $error("result word changed while stalled");

  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one in flight");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(status && pose_updated))
    else $error("dropped push reported as pose update");

  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("result word present after reset");

endmodule

bind keyframe_pose_interpolator kpi_checker u_kpi_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .pose_angle_0 (pose_angle_0),
  .pose_updated (pose_updated),
  .status       (status)
);

@@ tb/sv/tb_keyframe_pose_interpolator.sv @@
`timescale 1ns / 1ps
module tb_keyframe_pose_interpolator;
  import kpi_pkg::*;

  localparam int JOINTS      = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int N_RANDOM    = 1200;

  localparam logic [2:0] CFG_REST_0 = 3'd0;

  typedef struct {
    logic [2:0]        op;
    logic [2:0]        joint;
    logic signed [15:0] ang [ANGLES];
    logic [15:0]       steps;
    logic              rep;
  } op_word_t;

  typedef struct {
    logic signed [15:0] ang [ANGLES];
    logic              updated;
    logic              dropped;
  } pose_result_t;

  typedef struct {
    op_word_t     w;
    logic         fixed;
    pose_result_t res;
  } directed_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] operation = '0;
  logic [2:0] joint_index = '0;
  logic signed [15:0] key_angle_0 = '0, key_angle_1 = '0, key_angle_2 = '0;
  logic signed [15:0] key_angle_3 = '0, key_angle_4 = '0;
  logic [15:0] step_count = '0;
  logic repeat_on = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] pose_angle_0, pose_angle_1, pose_angle_2, pose_angle_3, pose_angle_4;
  logic pose_updated, status;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  keyframe_pose_interpolator dut (.*);

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  // shadow state of the block
  logic signed [15:0] rest_pose [ANGLES];
  logic signed [15:0] from_p [JOINTS][ANGLES];
  logic signed [15:0] to_p   [JOINTS][ANGLES];
  logic signed [15:0] cur_p  [JOINTS][ANGLES];
  logic [16:0] step_now [JOINTS];
  logic [15:0] step_total [JOINTS];
  logic signed [15:0] kf_ang [JOINTS][QUEUE_DEPTH][ANGLES];
  logic [15:0] kf_steps [JOINTS][QUEUE_DEPTH];
  int unsigned kf_head [JOINTS];
  int unsigned kf_fill [JOINTS];
  logic repeat_mode;

  pose_result_t pending_poses[$];
  int errors = 0;
  int received = 0;

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void reset_model();
    for (int a = 0; a < ANGLES; a++) rest_pose[a] = 0;
    for (int j = 0; j < JOINTS; j++) begin
      for (int a = 0; a < ANGLES; a++) begin
        from_p[j][a] = 0; to_p[j][a] = 0; cur_p[j][a] = 0;
      end
      step_now[j] = 1; step_total[j] = 1; kf_head[j] = 0; kf_fill[j] = 0;
    end
    repeat_mode = 0;
  endfunction

  function automatic void halt_joints();
    repeat_mode = 0;
    for (int j = 0; j < JOINTS; j++) begin
      kf_fill[j] = 0; kf_head[j] = 0;
      from_p[j] = to_p[j];
    end
  endfunction

  function automatic pose_result_t interpolate_pose(op_word_t w);
    pose_result_t r;
    int j;
    longint diff, term;
    int unsigned h, t;
    j = w.joint;
    r.updated = 0;
    r.dropped = 0;
    case (w.op)
      OP_TICK: begin
        if (step_now[j] <= step_total[j]) begin
          for (int a = 0; a < ANGLES; a++) begin
            diff = longint'(to_p[j][a]) - longint'(from_p[j][a]);
            term = 0;
            if (step_total[j] != 0)
              term = (diff * longint'(step_now[j])) / longint'(step_total[j]);
            cur_p[j][a] = 16'(longint'(from_p[j][a]) + term);
          end
          step_now[j] = step_now[j] + 1;
          r.updated = 1;
        end
        if (step_now[j] >= step_total[j]) begin
          from_p[j] = to_p[j];
          if (kf_fill[j] != 0) begin
            h = kf_head[j] % QUEUE_DEPTH;
            to_p[j] = kf_ang[j][h];
            step_total[j] = kf_steps[j][h];
            if (repeat_mode) begin
              t = (h + kf_fill[j]) % QUEUE_DEPTH;
              kf_ang[j][t] = kf_ang[j][h];
              kf_steps[j][t] = kf_steps[j][h];
            end else begin
              kf_fill[j]--;
            end
            kf_head[j] = (h + 1) % QUEUE_DEPTH;
            step_now[j] = 0;
          end
        end
      end
      OP_PUSH: begin
        if (kf_fill[j] >= QUEUE_DEPTH) begin
          r.dropped = 1;
        end else begin
          t = (kf_head[j] + kf_fill[j]) % QUEUE_DEPTH;
          kf_ang[j][t] = w.ang;
          kf_steps[j][t] = w.steps;
          kf_fill[j]++;
        end
      end
      OP_REPEAT: repeat_mode = w.rep;
      OP_STOP: halt_joints();
      OP_CLEAR: begin
        halt_joints();
        for (int k = 0; k < JOINTS; k++) begin
          from_p[k] = rest_pose; to_p[k] = rest_pose;
          step_now[k] = 1; step_total[k] = 1;
        end
      end
      default: ;
    endcase
    r.ang = cur_p[j];
    return r;
  endfunction

  // result side: random stalls in stall mode, field-by-field compare
  int stall_mode = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        pose_result_t e;
        logic signed [15:0] got [ANGLES];
        got = '{pose_angle_0, pose_angle_1, pose_angle_2, pose_angle_3, pose_angle_4};
        received++;
        if (pending_poses.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          e = pending_poses.pop_front();
          for (int a = 0; a < ANGLES; a++)
            if (got[a] !== e.ang[a])
              report($sformatf("pose_angle_%0d got %0d want %0d", a, got[a], e.ang[a]));
          if (pose_updated !== e.updated)
            report($sformatf("pose_updated got %b want %b", pose_updated, e.updated));
          if (status !== e.dropped)
            report($sformatf("status got %b want %b", status, e.dropped));
        end
      end
      if (stall_mode == 0) out_ready <= 1'b1;
      else if ($urandom_range(0, 19) == 0) out_ready <= ($urandom_range(0, 3) != 0);
      else if (!out_ready) out_ready <= ($urandom_range(0, 3) == 0);
      else out_ready <= ($urandom_range(0, 4) != 0);
    end
  end

  task automatic send_word(op_word_t w, output pose_result_t exp_res);
    int gap;
    // valid stays low for a random gap between words
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3);
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    operation <= w.op;
    joint_index <= w.joint;
    key_angle_0 <= w.ang[0]; key_angle_1 <= w.ang[1]; key_angle_2 <= w.ang[2];
    key_angle_3 <= w.ang[3]; key_angle_4 <= w.ang[4];
    step_count <= w.steps;
    repeat_on <= w.rep;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_res = interpolate_pose(w);
    pending_poses.push_back(exp_res);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_rest(logic signed [15:0] vals [ANGLES]);
    for (int a = 0; a < ANGLES; a++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_REST_0 + 3'(a);
      cfg_data <= vals[a];
      rest_pose[a] = vals[a];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic op_word_t make_word(logic [2:0] op, logic [2:0] j,
                                         logic signed [15:0] v, logic [15:0] s,
                                         logic rep);
    op_word_t w;
    w.op = op; w.joint = j; w.steps = s; w.rep = rep;
    for (int a = 0; a < ANGLES; a++) w.ang[a] = (a % 2) ? -v : v;
    return w;
  endfunction

  function automatic op_word_t random_word();
    op_word_t w;
    int p;
    p = $urandom_range(0, 99);
    w.joint = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
    w.rep = $urandom_range(0, 1);
    w.steps = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    for (int a = 0; a < ANGLES; a++) w.ang[a] = 16'($urandom);
    if (p < 55) w.op = OP_TICK;
    else if (p < 85) w.op = OP_PUSH;
    else if (p < 92) w.op = OP_REPEAT;
    else if (p < 95) w.op = OP_STOP;
    else if (p < 97) w.op = OP_CLEAR;
    else w.op = 3'($urandom_range(5, 7));
    return w;
  endfunction

  initial begin
    directed_row_t rows [$];
    directed_row_t row;
    pose_result_t got_exp;
    logic signed [15:0] rv [ANGLES];
    int n;

    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset: tick on joint 0 yields zero pose, counter already at total
    row.w = make_word(OP_TICK, 3'd0, 16'sd0, 16'd0, 1'b0);
    row.fixed = 1;
    row.res.ang = '{default: 16'sd0}; row.res.updated = 1; row.res.dropped = 0;
    rows.push_back(row);
    row.res.updated = 0;
    rows.push_back(row);
    row.fixed = 0;
    row.w = make_word(OP_PUSH, 3'd1, 16'sh7fff, 16'd4, 1'b0); rows.push_back(row);
    row.w = make_word(OP_PUSH, 3'd1, -16'sh8000, 16'hffff, 1'b0); rows.push_back(row);
    row.w = make_word(OP_PUSH, 3'd1, 16'sd100, 16'd0, 1'b0); rows.push_back(row);
    for (int i = 0; i < 6; i++) begin
      row.w = make_word(OP_TICK, 3'd1, 16'sd0, 16'd0, 1'b0); rows.push_back(row);
    end
    row.w = make_word(OP_REPEAT, 3'd0, 16'sd0, 16'd0, 1'b1); rows.push_back(row);
    row.w = make_word(OP_PUSH, 3'd7, 16'sh1234, 16'd2, 1'b0); rows.push_back(row);
    for (int i = 0; i < 4; i++) begin
      row.w = make_word(OP_TICK, 3'd7, 16'sd0, 16'd0, 1'b0); rows.push_back(row);
    end
    row.w = make_word(3'd5, 3'd1, 16'sd0, 16'd0, 1'b0); rows.push_back(row);
    row.w = make_word(3'd7, 3'd7, 16'sd0, 16'd0, 1'b1); rows.push_back(row);
    row.w = make_word(OP_STOP, 3'd2, 16'sd0, 16'd0, 1'b0); rows.push_back(row);
    row.w = make_word(OP_CLEAR, 3'd0, 16'sd0, 16'd0, 1'b0); rows.push_back(row);

    foreach (rows[i]) begin
      send_word(rows[i].w, got_exp);
      if (rows[i].fixed && (got_exp.ang != rows[i].res.ang ||
                            got_exp.updated != rows[i].res.updated ||
                            got_exp.dropped != rows[i].res.dropped))
        report($sformatf("directed row %0d disagrees with table", i));
    end

    // overfill joint 3 so the full-queue drop shows up
    for (int i = 0; i < QUEUE_DEPTH + 2; i++)
      send_word(make_word(OP_PUSH, 3'd3, 16'(i * 64), 16'd1, 1'b0), got_exp);

    // hold until everything is back, then move the rest pose
    drain();
    rv = '{16'sh7fff, -16'sh8000, 16'sd0, -16'sd1, 16'sd640};
    write_rest(rv);
    send_word(make_word(OP_CLEAR, 3'd0, 16'sd0, 16'd0, 1'b0), got_exp);

    n = 0;
    for (int phase = 0; phase < 4; phase++) begin
      stall_mode = (phase % 2 == 0) ? 1 : 0;
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        send_word(random_word(), got_exp);
        n++;
      end
      drain();
      for (int a = 0; a < ANGLES; a++)
        rv[a] = (phase == 2) ? -16'sh8000 : (phase == 3 ? 16'sh7fff : 16'($urandom));
      write_rest(rv);
      send_word(make_word(OP_CLEAR, 3'd0, 16'sd0, 16'd0, 1'b0), got_exp);
    end

    stall_mode = 0;
    drain();
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
